// ===== hw/rtl/abkf_pkg.sv =====
package abkf_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW = 31;

  localparam logic [CfgIdxW-1:0] RegAngleNoise = 2'd0;
  localparam logic [CfgIdxW-1:0] RegBiasNoise  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegMeasNoise  = 2'd2;

  localparam logic signed [31:0] AngleLimit = 32'sd23592960;
  localparam logic signed [31:0] BiasLimit  = 32'sd131072000;

  // Operations of the shared multiply-round unit.
  typedef struct packed {
    logic               start;
    logic signed [32:0] a;
    logic signed [35:0] b;
    logic               sh28;   // 0: shift by 24, 1: shift by 28
  } mul_req_t;

  typedef struct packed {
    logic               done;
    logic signed [35:0] res;    // rounded product
  } mul_rsp_t;

  typedef struct packed {
    logic               start;
    logic [59:0]        num;    // |P| << 28
    logic [32:0]        den;    // S, positive
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [59:0]        quo;
  } div_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

// ===== hw/rtl/angle_bias_kalman_filter.sv =====
// Two-state Kalman filter tracking tilt angle and gyro bias in Q16.16, with
// a Q4.28 2x2 covariance. Each input transfer runs the predict and update
// steps on one shared multiplier (ten products) and a bit-serial divider
// for the two gains (60 quotient bits each); the divisions are skipped when
// the innovation variance is not positive. s_tready is low until the item
// is done, so a new item is not taken while one is in progress. A load
// request only overwrites the angle estimate. The result is held in an
// output register until taken, which may stall the filter. Configuration
// writes are to be made while idle; writes to an index above two are ignored.
module angle_bias_kalman_filter (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  // tdata: measured_angle[24:0], measured_rate[52:25], time_step[76:53]
  input  logic [79:0] s_tdata,
  // tuser: load_angle
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // tdata: angle_out[25:0], bias_out[53:26]
  output logic [55:0] m_tdata
);
  import abkf_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_MUL   = 9'b000000010,
    ST_WAIT  = 9'b000000100,
    ST_DIV   = 9'b000001000,
    ST_DWAIT = 9'b000010000,
    ST_CALC  = 9'b000100000,
    ST_OUT   = 9'b001000000,
    ST_LOAD  = 9'b010000000,
    ST_SPARE = 9'b100000000
  } state_t;

  state_t state;
  logic [3:0] step;   // index of the current product in the sequence

  logic [30:0] q_angle, q_bias, r_meas;
  logic signed [31:0] angle_est, bias_est, p00, p01, p10, p11;
  logic signed [24:0] meas;
  logic [23:0] dt;
  logic signed [31:0] rate, t, y, k0, k1, q00, q01;
  logic signed [35:0] inner;
  logic gain_idx;

  mul_req_t mreq;
  mul_rsp_t mrsp;
  div_req_t dreq;
  div_rsp_t drsp;

  abkf_mul u_mul (.clk(clk), .rst(rst), .req(mreq), .rsp(mrsp));
  abkf_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  logic signed [32:0] s_var;
  logic signed [31:0] gain_p;
  logic signed [63:0] gain_q;
  logic signed [63:0] acc;
  logic signed [31:0] ang_c, bias_c;

  assign s_var = 33'(p00) + $signed({2'b0, r_meas});
  assign gain_p = gain_idx ? p10 : p00;
  assign gain_q = gain_p[31] ? -$signed({4'b0, drsp.quo}) : $signed({4'b0, drsp.quo});

  // Operand selection for each product of the sequence.
  always_comb begin
    mreq = '0;
    mreq.start = (state == ST_MUL);
    unique case (step)
      4'd0: begin mreq.a = 33'($signed({1'b0, dt})); mreq.b = 36'(rate); end
      4'd1: begin mreq.a = 33'($signed({1'b0, dt})); mreq.b = 36'(p11); end
      4'd2: begin mreq.a = 33'($signed({1'b0, dt})); mreq.b = inner; end
      4'd3: begin mreq.a = 33'($signed({1'b0, dt})); mreq.b = $signed({5'b0, q_bias}); end
      4'd4: begin mreq.a = 33'(k0); mreq.b = 36'(y); mreq.sh28 = 1'b1; end
      4'd5: begin mreq.a = 33'(k1); mreq.b = 36'(y); mreq.sh28 = 1'b1; end
      4'd6: begin mreq.a = 33'(k0); mreq.b = 36'(q00); mreq.sh28 = 1'b1; end
      4'd7: begin mreq.a = 33'(k0); mreq.b = 36'(q01); mreq.sh28 = 1'b1; end
      4'd8: begin mreq.a = 33'(k1); mreq.b = 36'(q00); mreq.sh28 = 1'b1; end
      default: begin mreq.a = 33'(k1); mreq.b = 36'(q01); mreq.sh28 = 1'b1; end
    endcase
    dreq.start = (state == ST_DIV);
    // The magnitude needs 32 bits, since the most negative covariance is allowed.
    dreq.num = {(gain_p[31] ? 32'(-33'(gain_p)) : {1'b0, gain_p[30:0]}), 28'b0};
    dreq.den = s_var[32:0];
  end

  assign acc = 64'(mrsp.res);
  assign s_tready = (state == ST_IDLE);

  // Output saturation to the stated ranges.
  always_comb begin
    ang_c = angle_est;
    if (angle_est > AngleLimit) ang_c = AngleLimit;
    else if (angle_est < -AngleLimit) ang_c = -AngleLimit;
    bias_c = bias_est;
    if (bias_est > BiasLimit) bias_c = BiasLimit;
    else if (bias_est < -BiasLimit) bias_c = -BiasLimit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      m_tvalid <= 1'b0;
      q_angle <= 31'd268435;
      q_bias <= 31'd805306;
      r_meas <= 31'd8053064;
      angle_est <= '0;
      bias_est <= '0;
      p00 <= '0; p01 <= '0; p10 <= '0; p11 <= '0;
      step <= '0;
      gain_idx <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          RegAngleNoise: q_angle <= cfg_data;
          RegBiasNoise:  q_bias <= cfg_data;
          RegMeasNoise:  r_meas <= cfg_data;
          default: ;
        endcase
      end
      // In ST_OUT the register is either refilled or left waiting below.
      if (m_tvalid && m_tready && state != ST_OUT) m_tvalid <= 1'b0;
      unique case (state)
        ST_IDLE: if (s_tvalid) begin
          meas <= s_tdata[24:0];
          dt <= s_tdata[76:53];
          step <= '0;
          if (s_tuser) begin
            angle_est <= 32'($signed(s_tdata[24:0]));
            state <= ST_OUT;
          end else begin
            rate <= sat32(64'($signed(s_tdata[52:25])) - 64'(bias_est));
            state <= ST_MUL;
          end
        end
        ST_MUL: state <= ST_WAIT;
        ST_WAIT: if (mrsp.done) begin
          state <= ST_MUL;
          step <= step + 4'd1;
          unique case (step)
            4'd0: angle_est <= sat32(64'(angle_est) + acc);
            4'd1: begin
              t <= mrsp.res[31:0];
              inner <= mrsp.res - 36'(p01) - 36'(p10) + $signed({5'b0, q_angle});
            end
            4'd2: begin
              p00 <= sat32(64'(p00) + acc);
              p01 <= sat32(64'(p01) - 64'(t));
              p10 <= sat32(64'(p10) - 64'(t));
            end
            4'd3: begin
              p11 <= sat32(64'(p11) + acc);
              y <= sat32(64'(meas) - 64'(angle_est));
              gain_idx <= 1'b0;
              state <= ST_CALC;
            end
            4'd4: angle_est <= sat32(64'(angle_est) + acc);
            4'd5: bias_est <= sat32(64'(bias_est) + acc);
            4'd6: p00 <= sat32(64'(q00) - acc);
            4'd7: p01 <= sat32(64'(q01) - acc);
            4'd8: p10 <= sat32(64'(p10) - acc);
            default: begin
              p11 <= sat32(64'(p11) - acc);
              state <= ST_OUT;
            end
          endcase
        end
        ST_CALC: begin
          q00 <= p00;
          q01 <= p01;
          if (s_var > 33'sd0) state <= ST_DIV;
          else begin
            k0 <= '0; k1 <= '0;
            state <= ST_MUL;
          end
        end
        ST_DIV: state <= ST_DWAIT;
        ST_DWAIT: if (drsp.done) begin
          if (!gain_idx) begin
            k0 <= sat32(gain_q);
            gain_idx <= 1'b1;
            state <= ST_DIV;
          end else begin
            k1 <= sat32(gain_q);
            state <= ST_MUL;
          end
        end
        ST_OUT: if (!m_tvalid || m_tready) begin
          m_tdata <= {2'b0, bias_c[27:0], ang_c[25:0]};
          m_tvalid <= 1'b1;
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> state == ST_IDLE) else $error("ready outside idle");
  a_out_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == ST_OUT) else $error("stray result");
  a_one_unit: assert property (@(posedge clk) disable iff (rst)
    !(mreq.start && dreq.start)) else $error("both units issued");
endmodule

// ===== hw/rtl/abkf_mul.sv =====
module abkf_mul (
  input  logic               clk,
  input  logic               rst,
  input  abkf_pkg::mul_req_t req,
  output abkf_pkg::mul_rsp_t rsp
);
  import abkf_pkg::*;

  logic signed [68:0] prod;
  logic               sh28;
  logic               stage;
  logic signed [68:0] rounded;

  // One registered product, then rounding to nearest with ties upward.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage <= 1'b0;
      rsp.done <= 1'b0;
    end else begin
      stage <= req.start;
      rsp.done <= stage;
    end
    if (req.start) begin
      prod <= req.a * req.b;
      sh28 <= req.sh28;
    end
    if (stage) rsp.res <= rounded[35:0];
  end

  always_comb begin
    if (sh28) rounded = (prod + 69'sd134217728) >>> 28;
    else rounded = (prod + 69'sd8388608) >>> 24;
  end

  initial_check: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> $past(stage)) else $error("multiplier result without issue");
endmodule

// ===== hw/rtl/abkf_div.sv =====
module abkf_div (
  input  logic               clk,
  input  logic               rst,
  input  abkf_pkg::div_req_t req,
  output abkf_pkg::div_rsp_t rsp
);
  import abkf_pkg::*;

  logic [59:0] quo;
  logic [33:0] rem;
  logic [32:0] den;
  logic [5:0]  cnt;
  logic        busy;
  logic [34:0] trial;
  logic [33:0] shifted;

  // Restoring division, one quotient bit a cycle.
  assign shifted = {rem[32:0], quo[59]};
  assign trial = {1'b0, shifted} - {2'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 6'd59) begin
        busy <= 1'b0;
        rsp.done <= 1'b1;
      end
    end
    if (req.start) begin
      quo <= req.num;
      den <= req.den;
      rem <= '0;
      cnt <= '0;
    end else if (busy) begin
      cnt <= cnt + 6'd1;
      if (!trial[34]) begin
        rem <= trial[33:0];
        quo <= {quo[58:0], 1'b1};
      end else begin
        rem <= shifted;
        quo <= {quo[58:0], 1'b0};
      end
    end
  end

  assign rsp.quo = quo;

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> $past(busy)) else $error("divider done while idle");
endmodule
